[hdl/stun_mapped_address_parser_assert.svh]
// Assertion macros shared by the STUN mapped address parser modules.
`ifndef STUN_MAPPED_ADDRESS_PARSER_ASSERT_SVH
`define STUN_MAPPED_ADDRESS_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMAP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/smap_pkg.sv]
// Types and constants of the STUN mapped address parser.
package smap_pkg;

   localparam int OFS_W = 18;
   localparam int SUM_W = OFS_W + 1;

   localparam logic [15:0] BINDING_SUCCESS = 16'h0101;
   localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
   localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
   localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
   localparam logic [15:0] PORT_MASK       = 16'h2112;
   localparam logic [31:0] ADDR_MASK       = 32'h2112A442;
   localparam logic [OFS_W-1:0] HEADER_BYTES = 18'd20;

   localparam logic [2:0] ST_FOUND      = 3'd0;
   localparam logic [2:0] ST_SHORT      = 3'd1;
   localparam logic [2:0] ST_WRONG_TYPE = 3'd2;
   localparam logic [2:0] ST_TRUNCATED  = 3'd3;
   localparam logic [2:0] ST_NO_ADDRESS = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] ipv4_address;
      logic [15:0] udp_port;
      logic        was_xor_form;
   } rsp_beat_type;

endpackage

[hdl/smap_core.sv]
// Per-datagram parser state: header fields, attribute walk and address capture.
`include "stun_mapped_address_parser_assert.svh"

module smap_core #(
   parameter int MAX_PACKET = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  smap_pkg::req_beat_type beat,
   output smap_pkg::rsp_beat_type result
);
   import smap_pkg::*;

   localparam int CW = $clog2(MAX_PACKET + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PACKET);

   logic [CW-1:0]    count_ff, count_in;
   logic [15:0]      mtype_ff, mtype_in;
   logic [15:0]      body_ff, body_in;
   logic [OFS_W-1:0] nho_ff, nho_in;
   logic [15:0]      atype_ff, atype_in;
   logic [15:0]      alen_ff, alen_in;
   logic [OFS_W-1:0] astart_ff, astart_in;
   logic             seen_ff, seen_in;
   logic             cand_ff, cand_in;
   logic [OFS_W-1:0] mend_ff, mend_in;
   logic [31:0]      maddr_ff, maddr_in;
   logic [15:0]      mport_ff, mport_in;
   logic             mxor_ff, mxor_in;

   logic [SUM_W-1:0] pos, cand_lo, cand_hi, vdiff;
   logic [SUM_W-1:0] hdr_lo, hdr_hi, hdiff, body_end, total;
   logic [SUM_W-1:0] nho_sum, mend_sum;
   logic [15:0]      len_full;
   logic [16:0]      len_round;
   logic [2:0]       vidx;
   logic [1:0]       hidx;
   logic             take;
   logic [2:0]       status;

   always_comb begin
      count_in  = count_ff;
      mtype_in  = mtype_ff;
      body_in   = body_ff;
      nho_in    = nho_ff;
      atype_in  = atype_ff;
      alen_in   = alen_ff;
      astart_in = astart_ff;
      seen_in   = seen_ff;
      cand_in   = cand_ff;
      mend_in   = mend_ff;
      maddr_in  = maddr_ff;
      mport_in  = mport_ff;
      mxor_in   = mxor_ff;

      take     = count_ff < MAX_COUNT;
      pos      = SUM_W'(count_ff);
      cand_lo  = {1'b0, astart_ff} + SUM_W'(4);
      cand_hi  = {1'b0, astart_ff} + SUM_W'(12);
      vdiff    = pos - cand_lo;
      vidx     = vdiff[2:0];
      hdr_lo   = {1'b0, nho_ff};
      hdr_hi   = hdr_lo + SUM_W'(4);
      hdiff    = pos - hdr_lo;
      hidx     = hdiff[1:0];
      body_end = {1'b0, HEADER_BYTES} + SUM_W'(body_ff);
      len_full = {alen_ff[15:8], beat.data_byte};
      // Attribute values are padded to a multiple of four bytes.
      len_round = ({1'b0, len_full} + 17'd3) & ~17'd3;
      nho_sum  = hdr_hi + SUM_W'(len_round);
      mend_sum = hdr_hi + SUM_W'(len_full);

      if (take) begin
         count_in = count_ff + CW'(1);
         if (count_ff == CW'(0)) begin
            mtype_in = {beat.data_byte, 8'h00};
         end else if (count_ff == CW'(1)) begin
            mtype_in = {mtype_ff[15:8], beat.data_byte};
         end else if (count_ff == CW'(2)) begin
            body_in = {beat.data_byte, 8'h00};
         end else if (count_ff == CW'(3)) begin
            body_in = {body_ff[15:8], beat.data_byte};
         end

         if (cand_ff && pos >= cand_lo && pos < cand_hi) begin
            if (vidx == 3'd1 && beat.data_byte != FAMILY_IPV4) begin
               cand_in = 1'b0;
            end else if (vidx == 3'd2) begin
               mport_in = {beat.data_byte, 8'h00};
            end else if (vidx == 3'd3) begin
               mport_in = {mport_ff[15:8], beat.data_byte};
            end else if (vidx >= 3'd4) begin
               maddr_in = {maddr_ff[23:0], beat.data_byte};
               if (vidx == 3'd7) begin
                  mxor_in = (atype_ff == ATTR_XOR_MAPPED);
                  if (atype_ff == ATTR_XOR_MAPPED) begin
                     mport_in = mport_ff ^ PORT_MASK;
                     maddr_in = {maddr_ff[23:0], beat.data_byte} ^ ADDR_MASK;
                  end
                  seen_in = 1'b1;
                  cand_in = 1'b0;
               end
            end
         end

         // The walk stops once an address is captured, including on this byte.
         if (!seen_in && pos >= {1'b0, HEADER_BYTES} && hdr_hi <= body_end &&
             pos >= hdr_lo && pos < hdr_hi) begin
            case (hidx)
               2'd0: atype_in = {beat.data_byte, 8'h00};
               2'd1: atype_in = {atype_ff[15:8], beat.data_byte};
               2'd2: alen_in  = {beat.data_byte, 8'h00};
               default: begin
                  alen_in   = len_full;
                  astart_in = nho_ff;
                  nho_in    = nho_sum[OFS_W-1:0];
                  mend_in   = mend_sum[OFS_W-1:0];
                  cand_in   = (atype_ff == ATTR_XOR_MAPPED || atype_ff == ATTR_MAPPED) &&
                              len_full >= 16'd8;
               end
            endcase
         end
      end

      total = SUM_W'(count_in);
      if (total < {1'b0, HEADER_BYTES}) begin
         status = ST_SHORT;
      end else if (mtype_in != BINDING_SUCCESS) begin
         status = ST_WRONG_TYPE;
      end else if (SUM_W'(body_in) + {1'b0, HEADER_BYTES} > total) begin
         status = ST_TRUNCATED;
      end else if (seen_in && {1'b0, mend_in} <= total) begin
         status = ST_FOUND;
      end else begin
         status = ST_NO_ADDRESS;
      end

      result.status       = status;
      result.ipv4_address = (status == ST_FOUND) ? maddr_in : 32'd0;
      result.udp_port     = (status == ST_FOUND) ? mport_in : 16'd0;
      result.was_xor_form = (status == ST_FOUND) && mxor_in;
   end

   // The last beat of a datagram returns the parser to its idle values.
   always_ff @(posedge clock) begin
      if (reset || (step && beat.last_byte)) begin
         count_ff  <= '0;
         mtype_ff  <= '0;
         body_ff   <= '0;
         nho_ff    <= HEADER_BYTES;
         atype_ff  <= '0;
         alen_ff   <= '0;
         astart_ff <= '0;
         seen_ff   <= 1'b0;
         cand_ff   <= 1'b0;
         mend_ff   <= '0;
         maddr_ff  <= '0;
         mport_ff  <= '0;
         mxor_ff   <= 1'b0;
      end else if (step) begin
         count_ff  <= count_in;
         mtype_ff  <= mtype_in;
         body_ff   <= body_in;
         nho_ff    <= nho_in;
         atype_ff  <= atype_in;
         alen_ff   <= alen_in;
         astart_ff <= astart_in;
         seen_ff   <= seen_in;
         cand_ff   <= cand_in;
         mend_ff   <= mend_in;
         maddr_ff  <= maddr_in;
         mport_ff  <= mport_in;
         mxor_ff   <= mxor_in;
      end
   end

   `SMAP_ASSERT_NEXT(a_last_clears, clock, reset, step && beat.last_byte, count_ff == '0 && !seen_ff && nho_ff == HEADER_BYTES, "parser state not cleared after last beat")
   `SMAP_ASSERT_SAME(a_seen_no_cand, clock, reset, seen_ff, !cand_ff, "candidate still open after capture")
   `SMAP_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_COUNT, "byte count above saturation")
   `SMAP_ASSERT_NEXT(a_walk_frozen, clock, reset, seen_ff && step && !beat.last_byte, $stable(nho_ff) && $stable(maddr_ff), "attribute walk moved after capture")

endmodule

[hdl/stun_mapped_address_parser.sv]
// Top level of the STUN mapped address parser: input register, parser and result register.
//
// One beat on the req_ channel carries one byte of a received STUN datagram,
// with last_byte set on the final byte. Beats may follow one another in every
// cycle; the parser takes one byte per clock except while a final byte waits
// on a held result, the rate being set by the single state update in smap_core,
// which sits between the input register and the result register.
// A datagram produces exactly one beat on the rsp_ channel once its last byte
// has passed the input register and then the result register.
// Other bytes produce no result.
// The result carries the status (found, too short, wrong type, truncated
// body, no address) with the decoded IPv4 address and port when found.
// Bytes beyond MAX_PACKET are dropped, and the byte count saturates there.
// While rsp_stall holds a result, the block keeps taking non-final bytes of
// the next datagram; only a final byte waits, and then req_stall is raised.
// Reset is synchronous and leaves the block empty and ready for a new
// datagram.
`include "stun_mapped_address_parser_assert.svh"

module stun_mapped_address_parser #(
   parameter int MAX_PACKET = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  smap_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output smap_pkg::rsp_beat_type rsp_data
);
   import smap_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_beat_type in_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_data_ff;
   rsp_beat_type core_result;
   logic         out_free, step;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign step        = in_valid_ff && (!in_data_ff.last_byte || out_free);
   assign req_stall   = in_valid_ff && !step;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && in_data_ff.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   smap_core #(
      .MAX_PACKET(MAX_PACKET)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .beat  (in_data_ff),
      .result(core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (step && in_data_ff.last_byte) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SMAP_ASSERT_SAME(a_last_waits, clock, reset, in_valid_ff && in_data_ff.last_byte && rsp_valid_ff && rsp_stall, req_stall && !step, "final byte advanced over a held result")
   `SMAP_ASSERT_NEXT(a_result_follows, clock, reset, step && in_data_ff.last_byte, rsp_valid_ff, "no result after final byte")
   `SMAP_ASSERT_SAME(a_plain_byte_flows, clock, reset, in_valid_ff && !in_data_ff.last_byte, !req_stall, "non-final byte stalled")

endmodule
